[rtl/bccs_pkg.sv]
// Shared types, codes and constants of the byte-coded processor step unit.
`default_nettype none

package bccs_pkg;

  // Default memory sizes in bytes.
  localparam int unsigned MEM_BYTES_DEF     = 65536;
  localparam int unsigned PERSIST_BYTES_DEF = 4096;

  // Configuration port.
  localparam int CFG_IW = 2;
  localparam int CFG_DW = 32;
  localparam logic [CFG_IW-1:0] CFG_PERSIST_EN = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_HALT_EN    = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_HALT_ADDR  = 2'd2;

  // Item commands.
  localparam logic [1:0] CMD_WMAIN = 2'd0;
  localparam logic [1:0] CMD_WPERS = 2'd1;
  localparam logic [1:0] CMD_EXEC  = 2'd2;

  // Error codes.
  localparam logic [2:0] ERR_NONE    = 3'd0;
  localparam logic [2:0] ERR_NO_CMP  = 3'd1;
  localparam logic [2:0] ERR_BAD_BR  = 3'd2;
  localparam logic [2:0] ERR_NO_PERS = 3'd3;
  localparam logic [2:0] ERR_BAD_OP  = 3'd4;

  // Opcodes and opcode ranges.
  localparam logic [7:0] OP_NOP    = 8'h00;
  localparam logic [7:0] OP_IN     = 8'h01;
  localparam logic [7:0] OP_OUT    = 8'h02;
  localparam logic [7:0] OP_KEY    = 8'h03;
  localparam logic [7:0] OP_SCR    = 8'h04;
  localparam logic [7:0] OP_TLO    = 8'h05;
  localparam logic [7:0] OP_THI    = 8'h06;
  localparam logic [7:0] OP_PC     = 8'h07;
  localparam logic [7:0] OP_OUTI   = 8'h12;
  localparam logic [7:0] OP_SCRI   = 8'h14;
  localparam logic [7:0] OP_ALU_LO = 8'h20;
  localparam logic [7:0] OP_ALU_HI = 8'h3a;
  localparam logic [7:0] OP_BR_LO  = 8'h40;
  localparam logic [7:0] OP_BR_HI  = 8'h5f;
  localparam logic [7:0] OP_MEM_LO = 8'h60;
  localparam logic [7:0] OP_MEM_HI = 8'h77;

  // Branch conditions after the immediate bit is masked off.
  localparam logic [7:0] BR_MASK   = 8'hef;
  localparam logic [7:0] BR_ALWAYS = 8'h48;
  localparam logic [7:0] BR_EQ     = 8'h41;
  localparam logic [7:0] BR_NE     = 8'h49;
  localparam logic [7:0] BR_LTU    = 8'h42;
  localparam logic [7:0] BR_GEU    = 8'h4a;
  localparam logic [7:0] BR_LEU    = 8'h43;
  localparam logic [7:0] BR_GTU    = 8'h4b;
  localparam logic [7:0] BR_LT     = 8'h44;
  localparam logic [7:0] BR_GE     = 8'h4c;
  localparam logic [7:0] BR_LE     = 8'h45;
  localparam logic [7:0] BR_GT     = 8'h4d;

  // ALU function codes.
  localparam logic [3:0] ALU_NAND = 4'd0;
  localparam logic [3:0] ALU_OR   = 4'd1;
  localparam logic [3:0] ALU_AND  = 4'd2;
  localparam logic [3:0] ALU_NOR  = 4'd3;
  localparam logic [3:0] ALU_ADD  = 4'd4;
  localparam logic [3:0] ALU_SUB  = 4'd5;
  localparam logic [3:0] ALU_XOR  = 4'd6;
  localparam logic [3:0] ALU_SHL  = 4'd7;
  localparam logic [3:0] ALU_SHR  = 4'd8;
  localparam logic [3:0] ALU_SRA  = 4'd9;
  localparam logic [3:0] ALU_CMP  = 4'd10;

  // Memory access codes in the low opcode bits.
  localparam logic [2:0] MC_PLOAD  = 3'd3;
  localparam logic [2:0] MC_PSTORE = 3'd7;

  localparam logic [31:0] SIGN_FLIP = 32'h8000_0000;

  typedef enum logic [1:0] {RS_LOAD, RS_PC, RS_OPND} red_src_t;
  typedef enum logic [1:0] {MK_NONE, MK_LOAD, MK_STORE} mem_kind_t;

  // Input word.
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] load_address;
    logic [7:0]  load_byte;
    logic        input_available;
    logic [31:0] input_word;
    logic        key_available;
    logic [31:0] key_word;
    logic [63:0] time_now;
  } in_t;

  // Result word.
  typedef struct packed {
    logic        stopped;
    logic [2:0]  error_code;
    logic        out_valid;
    logic [31:0] out_value;
    logic        screen_valid;
    logic [31:0] screen_setting;
    logic [31:0] screen_value;
    logic        input_taken;
    logic        key_taken;
    logic [31:0] pc_now;
    logic [31:0] reg_one;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     capture;
    logic     red_start;
    red_src_t red_src;
    logic     red_persist;
    logic     ptr_load;
    logic     mem_rd;
    logic     rd_ibuf;
    logic     mem_wr;
    logic     wr_load;
    logic     rf_read;
    logic     exec;
    logic     commit;
    logic     set_halt;
    logic     set_err3;
    logic     res_load;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic      red_done;
    logic      halt_hit;
    logic      persist_en;
    logic [1:0] cmd;
    logic      err_any;
    mem_kind_t mkind;
    logic      mem_persist;
    logic [1:0] mlen_m1;
    logic      out_free;
  } dp_sts_t;

endpackage

`default_nettype wire

[rtl/byte_coded_cpu_step_unit.sv]
// Top level of the byte-coded processor step unit.
//
//   channel   signals                      word      accepted when
//   input     in_valid, in_ready, in_data  in_t      in_valid && in_ready
//   result    res_valid, res_ready, res_data out_t   res_valid && res_ready
//   config    cfg_we, cfg_index, cfg_data  32 bits   cfg_we
//
// Words are taken one at a time. A memory write reduces its address and writes the
// byte; an executed instruction runs address reduction, four byte fetches, register
// read, execute, commit and result, with a second reduction and one access per data
// byte for loads and stores; a fault skips commit; halt and rejected words go to result.
// Reset is synchronous and clears the registers, pc and compare state; memories
// are not cleared. A finished word waits in the output register; a stall occurs
// only when the next word is finished before that one has been accepted.
`default_nettype none

module byte_coded_cpu_step_unit #(
  parameter int unsigned MEM_BYTES     = bccs_pkg::MEM_BYTES_DEF,
  parameter int unsigned PERSIST_BYTES = bccs_pkg::PERSIST_BYTES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  bccs_pkg::in_t               in_data,
  output logic                        res_valid,
  input  logic                        res_ready,
  output bccs_pkg::out_t              res_data,
  input  logic                        cfg_we,
  input  logic [bccs_pkg::CFG_IW-1:0] cfg_index,
  input  logic [bccs_pkg::CFG_DW-1:0] cfg_data
);

  bccs_pkg::dp_cmd_t cmd;
  bccs_pkg::dp_sts_t sts;

  // Controller.
  bccs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Datapath.
  bccs_dp #(
    .MEM_BYTES     (MEM_BYTES),
    .PERSIST_BYTES (PERSIST_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res_data  (res_data)
  );

endmodule

`default_nettype wire

[rtl/bccs_mod.sv]
// Address reduction modulo a memory size by reciprocal multiplication: quotient estimate, remainder, then correction.
`default_nettype none

module bccs_mod #(
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [31:0]   value,
  input  logic [DW-1:0] divisor,
  input  logic [31:0]   recip,
  output logic          done,
  output logic [DW-1:0] rem
);

  logic [63:0] prod;
  logic [31:0] acc, dcap, quo, qd, diff, fix;
  logic        s1, s2;

  // The quotient estimate is low by at most one, so one correction step suffices.
  assign prod = 64'(value) * 64'(recip);
  assign qd   = quo * dcap;
  assign fix  = (diff >= dcap) ? diff - dcap : diff;

  // Start: estimate the quotient. Then form the remainder, then correct it.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1   <= 1'b0;
      s2   <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      acc  <= value;
      dcap <= 32'(divisor);
      quo  <= prod[63:32];
      s1   <= 1'b1;
      s2   <= 1'b0;
      done <= 1'b0;
    end else if (s1) begin
      diff <= acc - qd;
      s1   <= 1'b0;
      s2   <= 1'b1;
    end else if (s2) begin
      rem  <= fix[DW-1:0];
      s2   <= 1'b0;
      done <= 1'b1;
    end
  end

endmodule

`default_nettype wire

[rtl/bccs_ctrl.sv]
// Sequencing state machine of the byte-coded processor step unit.
`default_nettype none

module bccs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  bccs_pkg::dp_sts_t sts,
  output bccs_pkg::dp_cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_WAIT_RED, S_WBYTE, S_FETCH, S_FWAIT,
    S_RFRD, S_EXEC, S_DATA, S_DWAIT, S_COMMIT, S_RESULT
  } state_t;

  typedef enum logic [1:0] {PH_WRITE, PH_FETCH, PH_DATA} phase_t;

  state_t     state, state_next;
  phase_t     phase, phase_next;
  logic [1:0] cnt, cnt_next;

  // Next state and datapath commands.
  always_comb begin
    state_next = state;
    phase_next = phase;
    cnt_next   = cnt;
    cmd        = '0;
    in_ready   = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.cmd)
          bccs_pkg::CMD_WMAIN: begin
            cmd.red_start = 1'b1;
            cmd.red_src   = bccs_pkg::RS_LOAD;
            phase_next    = PH_WRITE;
            state_next    = S_WAIT_RED;
          end
          bccs_pkg::CMD_WPERS: begin
            if (sts.persist_en) begin
              cmd.red_start   = 1'b1;
              cmd.red_src     = bccs_pkg::RS_LOAD;
              cmd.red_persist = 1'b1;
              phase_next      = PH_WRITE;
              state_next      = S_WAIT_RED;
            end else begin
              cmd.set_err3 = 1'b1;
              state_next   = S_RESULT;
            end
          end
          bccs_pkg::CMD_EXEC: begin
            if (sts.halt_hit) begin
              cmd.set_halt = 1'b1;
              state_next   = S_RESULT;
            end else begin
              cmd.red_start = 1'b1;
              cmd.red_src   = bccs_pkg::RS_PC;
              phase_next    = PH_FETCH;
              state_next    = S_WAIT_RED;
            end
          end
          default: state_next = S_RESULT;
        endcase
      end
      S_WAIT_RED: begin
        if (sts.red_done) begin
          cmd.ptr_load = 1'b1;
          cnt_next     = 2'd0;
          case (phase)
            PH_WRITE: state_next = S_WBYTE;
            PH_FETCH: state_next = S_FETCH;
            default:  state_next = S_DATA;
          endcase
        end
      end
      S_WBYTE: begin
        cmd.mem_wr  = 1'b1;
        cmd.wr_load = 1'b1;
        state_next  = S_RESULT;
      end
      S_FETCH: begin
        cmd.mem_rd  = 1'b1;
        cmd.rd_ibuf = 1'b1;
        cnt_next    = cnt + 2'd1;
        if (cnt == 2'd3) begin
          state_next = S_FWAIT;
        end
      end
      S_FWAIT: state_next = S_RFRD;
      S_RFRD: begin
        cmd.rf_read = 1'b1;
        state_next  = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec = 1'b1;
        if (sts.err_any) begin
          state_next = S_RESULT;
        end else if (sts.mkind != bccs_pkg::MK_NONE) begin
          cmd.red_start   = 1'b1;
          cmd.red_src     = bccs_pkg::RS_OPND;
          cmd.red_persist = sts.mem_persist;
          phase_next      = PH_DATA;
          state_next      = S_WAIT_RED;
        end else begin
          state_next = S_COMMIT;
        end
      end
      S_DATA: begin
        if (sts.mkind == bccs_pkg::MK_LOAD) begin
          cmd.mem_rd = 1'b1;
        end else begin
          cmd.mem_wr = 1'b1;
        end
        cnt_next = cnt + 2'd1;
        if (cnt == sts.mlen_m1) begin
          state_next = (sts.mkind == bccs_pkg::MK_LOAD) ? S_DWAIT : S_COMMIT;
        end
      end
      S_DWAIT: state_next = S_COMMIT;
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = S_RESULT;
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      phase <= PH_WRITE;
      cnt   <= 2'd0;
    end else begin
      state <= state_next;
      phase <= phase_next;
      cnt   <= cnt_next;
    end
  end

endmodule

`default_nettype wire

[rtl/bccs_dp.sv]
// Datapath: memories, register file, decode, ALU and the result register.
`default_nettype none

module bccs_dp #(
  parameter int unsigned MEM_BYTES     = bccs_pkg::MEM_BYTES_DEF,
  parameter int unsigned PERSIST_BYTES = bccs_pkg::PERSIST_BYTES_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  bccs_pkg::in_t                 in_data,
  input  logic                          cfg_we,
  input  logic [bccs_pkg::CFG_IW-1:0]   cfg_index,
  input  logic [bccs_pkg::CFG_DW-1:0]   cfg_data,
  input  bccs_pkg::dp_cmd_t             cmd,
  output bccs_pkg::dp_sts_t             sts,
  output logic                          res_valid,
  input  logic                          res_ready,
  output bccs_pkg::out_t                res_data
);

  localparam int AW = $clog2(MEM_BYTES);
  localparam int PW = $clog2(PERSIST_BYTES);
  localparam int DW = $clog2(((MEM_BYTES > PERSIST_BYTES) ? MEM_BYTES : PERSIST_BYTES) + 1);
  localparam logic [31:0] MEM_RECIP  = 32'((64'd1 << 32) / 64'(MEM_BYTES));
  localparam logic [31:0] PERS_RECIP = 32'((64'd1 << 32) / 64'(PERSIST_BYTES));

  // Configuration and architectural state.
  logic          persist_en, halt_en;
  logic [31:0]   halt_addr;
  bccs_pkg::in_t item;
  logic [31:0]   pc, reg1, cmp_left, cmp_right;
  logic          cmp_valid;
  logic [15:0]   rf_valid;
  logic [31:0]   rf [16];
  logic [31:0]   ra, rb;

  // Memory access state.
  logic [7:0]    main_mem [MEM_BYTES];
  logic [7:0]    pers_mem [PERSIST_BYTES];
  logic [AW-1:0] mptr;
  logic [PW-1:0] pptr;
  logic [7:0]    mrd, prd, rd_byte, wbyte;
  logic          acc_p, rd_pend, rd_ibuf, rd_p;
  logic [31:0]   ibuf, dbuf, sdata;
  bccs_pkg::out_t rr, rr_exec, res_next;

  // Reduction unit connections.
  logic [31:0]   red_value, red_recip;
  logic [DW-1:0] red_div, red_rem;
  logic          red_done;

  // Decode results.
  logic [7:0]  op, b1, b2, br_base;
  logic [3:0]  dst, alu_code;
  logic [2:0]  mcode;
  logic        im, take;
  logic [31:0] opnd, pc_len, alu_val, sa, sb;
  logic [2:0]  d_err;
  logic        d_wb, d_cset, d_cclr, d_mp, d_ov, d_sv, d_it, d_kt;
  logic [31:0] d_wval, d_next;
  bccs_pkg::mem_kind_t d_mk;
  logic [1:0]  d_mlen;

  assign op       = ibuf[31:24];
  assign b1       = ibuf[23:16];
  assign b2       = ibuf[15:8];
  assign dst      = b1[7:4];
  assign im       = op[4];
  assign opnd     = im ? {16'h0, ibuf[15:0]} : rb;
  assign pc_len   = im ? pc + 32'd4 : pc + 32'd3;
  assign alu_code = op[3:0];
  assign mcode    = op[2:0];
  assign br_base  = op & bccs_pkg::BR_MASK;
  assign sa       = cmp_left ^ bccs_pkg::SIGN_FLIP;
  assign sb       = cmp_right ^ bccs_pkg::SIGN_FLIP;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      persist_en <= 1'b0;
      halt_en    <= 1'b0;
      halt_addr  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        bccs_pkg::CFG_PERSIST_EN: persist_en <= cfg_data[0];
        bccs_pkg::CFG_HALT_EN:    halt_en    <= cfg_data[0];
        bccs_pkg::CFG_HALT_ADDR:  halt_addr  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Address reduction source, modulus and its reciprocal.
  always_comb begin
    case (cmd.red_src)
      bccs_pkg::RS_LOAD: red_value = {16'h0, item.load_address};
      bccs_pkg::RS_PC:   red_value = pc;
      default:           red_value = opnd;
    endcase
    red_div   = cmd.red_persist ? DW'(PERSIST_BYTES) : DW'(MEM_BYTES);
    red_recip = cmd.red_persist ? PERS_RECIP : MEM_RECIP;
  end

  bccs_mod #(.DW(DW)) u_mod (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.red_start),
    .value   (red_value),
    .divisor (red_div),
    .recip   (red_recip),
    .done    (red_done),
    .rem     (red_rem)
  );

  // ALU.
  always_comb begin
    case (alu_code)
      bccs_pkg::ALU_NAND: alu_val = ~(ra & opnd);
      bccs_pkg::ALU_OR:   alu_val = ra | opnd;
      bccs_pkg::ALU_AND:  alu_val = ra & opnd;
      bccs_pkg::ALU_NOR:  alu_val = ~(ra | opnd);
      bccs_pkg::ALU_ADD:  alu_val = ra + opnd;
      bccs_pkg::ALU_SUB:  alu_val = ra - opnd;
      bccs_pkg::ALU_XOR:  alu_val = ra ^ opnd;
      bccs_pkg::ALU_SHL:  alu_val = (opnd[31:5] == '0) ? ra << opnd[4:0] : '0;
      bccs_pkg::ALU_SHR:  alu_val = (opnd[31:5] == '0) ? ra >> opnd[4:0] : '0;
      default: begin
        if (opnd[31:5] != '0) begin
          alu_val = {32{ra[31]}};
        end else begin
          alu_val = $unsigned($signed(ra) >>> opnd[4:0]);
        end
      end
    endcase
  end

  // Instruction decode: every effect of the instruction at pc.
  always_comb begin
    d_err  = bccs_pkg::ERR_NONE;
    d_wb   = 1'b0;
    d_wval = '0;
    d_next = pc + 32'd1;
    d_cset = 1'b0;
    d_cclr = 1'b0;
    d_mk   = bccs_pkg::MK_NONE;
    d_mp   = 1'b0;
    d_mlen = 2'd0;
    d_ov   = 1'b0;
    d_sv   = 1'b0;
    d_it   = 1'b0;
    d_kt   = 1'b0;
    take   = 1'b0;
    if (op == bccs_pkg::OP_NOP) begin
      d_next = pc + 32'd1;
    end else if (op == bccs_pkg::OP_IN) begin
      d_wb   = 1'b1;
      d_wval = item.input_available ? item.input_word : '0;
      d_it   = item.input_available;
      d_next = pc + 32'd2;
    end else if (op == bccs_pkg::OP_OUT || op == bccs_pkg::OP_OUTI) begin
      d_ov   = 1'b1;
      d_next = pc_len;
    end else if (op == bccs_pkg::OP_KEY) begin
      d_wb   = 1'b1;
      d_wval = item.key_available ? item.key_word : '0;
      d_kt   = item.key_available;
      d_next = pc + 32'd2;
    end else if (op == bccs_pkg::OP_SCR || op == bccs_pkg::OP_SCRI) begin
      d_sv   = 1'b1;
      d_next = pc_len;
    end else if (op == bccs_pkg::OP_TLO || op == bccs_pkg::OP_THI) begin
      d_wb   = 1'b1;
      d_wval = (op == bccs_pkg::OP_TLO) ? item.time_now[31:0] : item.time_now[63:32];
      d_next = pc + 32'd2;
    end else if (op == bccs_pkg::OP_PC) begin
      d_wb   = 1'b1;
      d_wval = pc;
      d_cclr = (dst == 4'd15);
      d_next = pc + 32'd2;
    end else if (op >= bccs_pkg::OP_ALU_LO && op <= bccs_pkg::OP_ALU_HI
                 && alu_code <= bccs_pkg::ALU_CMP) begin
      d_wb   = 1'b1;
      d_next = pc_len;
      if (alu_code == bccs_pkg::ALU_CMP) begin
        d_cset = 1'b1;
        d_wval = '0;
      end else begin
        d_wval = alu_val;
        d_cclr = (dst == 4'd15);
      end
    end else if (op >= bccs_pkg::OP_BR_LO && op <= bccs_pkg::OP_BR_HI) begin
      d_next = pc_len;
      if (br_base == bccs_pkg::BR_ALWAYS) begin
        take = 1'b1;
      end else if (!cmp_valid) begin
        d_err = bccs_pkg::ERR_NO_CMP;
      end else begin
        case (br_base)
          bccs_pkg::BR_EQ:  take = cmp_left == cmp_right;
          bccs_pkg::BR_NE:  take = cmp_left != cmp_right;
          bccs_pkg::BR_LTU: take = cmp_left < cmp_right;
          bccs_pkg::BR_GEU: take = cmp_left >= cmp_right;
          bccs_pkg::BR_LEU: take = cmp_left <= cmp_right;
          bccs_pkg::BR_GTU: take = cmp_left > cmp_right;
          bccs_pkg::BR_LT:  take = sa < sb;
          bccs_pkg::BR_GE:  take = sa >= sb;
          bccs_pkg::BR_LE:  take = sa <= sb;
          bccs_pkg::BR_GT:  take = sa > sb;
          default:          d_err = bccs_pkg::ERR_BAD_BR;
        endcase
      end
      if (take) begin
        d_next = opnd;
      end
    end else if (op >= bccs_pkg::OP_MEM_LO && op <= bccs_pkg::OP_MEM_HI) begin
      d_next = pc_len;
      d_wval = dbuf;
      if (mcode == bccs_pkg::MC_PLOAD || mcode == bccs_pkg::MC_PSTORE) begin
        if (!persist_en) begin
          d_err = bccs_pkg::ERR_NO_PERS;
        end else begin
          d_mp   = 1'b1;
          d_mlen = 2'd3;
          if (mcode == bccs_pkg::MC_PLOAD) begin
            d_mk = bccs_pkg::MK_LOAD;
            d_wb = 1'b1;
          end else begin
            d_mk = bccs_pkg::MK_STORE;
          end
        end
      end else begin
        d_mlen = (mcode[1:0] == 2'd0) ? 2'd0 : ((mcode[1:0] == 2'd1) ? 2'd1 : 2'd3);
        if (!mcode[2]) begin
          d_mk   = bccs_pkg::MK_LOAD;
          d_wb   = 1'b1;
          d_cclr = (dst == 4'd15);
        end else begin
          d_mk = bccs_pkg::MK_STORE;
        end
      end
    end else begin
      d_err = bccs_pkg::ERR_BAD_OP;
    end
  end

  // Byte memories: one write and one registered read each.
  assign wbyte   = cmd.wr_load ? item.load_byte : sdata[31:24];
  assign rd_byte = rd_p ? prd : mrd;

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && !acc_p) begin
      main_mem[mptr] <= wbyte;
    end
    mrd <= main_mem[mptr];
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_wr && acc_p) begin
      pers_mem[pptr] <= wbyte;
    end
    prd <= pers_mem[pptr];
  end

  // Byte pointers, wrapping at the memory size.
  always_ff @(posedge clk) begin
    if (cmd.red_start) begin
      acc_p <= cmd.red_persist;
    end
    if (cmd.ptr_load) begin
      if (acc_p) begin
        pptr <= red_rem[PW-1:0];
      end else begin
        mptr <= red_rem[AW-1:0];
      end
    end else if (cmd.mem_rd || cmd.mem_wr) begin
      if (acc_p) begin
        pptr <= (pptr == PW'(PERSIST_BYTES - 1)) ? '0 : pptr + PW'(1);
      end else begin
        mptr <= (mptr == AW'(MEM_BYTES - 1)) ? '0 : mptr + AW'(1);
      end
    end
  end

  // Read return: shift into the instruction or data buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.mem_rd;
    end
    rd_ibuf <= cmd.rd_ibuf;
    rd_p    <= acc_p;
    if (rd_pend) begin
      if (rd_ibuf) begin
        ibuf <= {ibuf[23:0], rd_byte};
      end else begin
        dbuf <= {dbuf[23:0], rd_byte};
      end
    end else if (cmd.exec) begin
      dbuf <= '0;
    end
    if (cmd.exec) begin
      case (d_mlen)
        2'd0:    sdata <= {ra[7:0], 24'h0};
        2'd1:    sdata <= {ra[15:0], 16'h0};
        default: sdata <= ra;
      endcase
    end else if (cmd.mem_wr && !cmd.wr_load) begin
      sdata <= {sdata[23:0], 8'h0};
    end
  end

  // Register file: two registered read ports, entries not yet written read as zero.
  always_ff @(posedge clk) begin
    if (cmd.rf_read) begin
      ra <= rf_valid[b1[3:0]] ? rf[b1[3:0]] : '0;
      rb <= rf_valid[b2[3:0]] ? rf[b2[3:0]] : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && d_wb && dst != 4'd0) begin
      rf[dst] <= d_wval;
    end
  end

  // Committed state.
  always_ff @(posedge clk) begin
    if (rst) begin
      rf_valid  <= '0;
      pc        <= '0;
      reg1      <= '0;
      cmp_valid <= 1'b0;
      cmp_left  <= '0;
      cmp_right <= '0;
    end else if (cmd.commit) begin
      pc <= d_next;
      if (d_wb && dst != 4'd0) begin
        rf_valid[dst] <= 1'b1;
        if (dst == 4'd1) begin
          reg1 <= d_wval;
        end
      end
      if (d_cset) begin
        cmp_valid <= 1'b1;
        cmp_left  <= ra;
        cmp_right <= opnd;
      end else if (d_cclr) begin
        cmp_valid <= 1'b0;
      end
    end
  end

  // Result fields of an executed instruction.
  always_comb begin
    rr_exec = '0;
    if (d_err != bccs_pkg::ERR_NONE) begin
      rr_exec.error_code = d_err;
    end else begin
      rr_exec.stopped        = (d_next == pc);
      rr_exec.out_valid      = d_ov;
      rr_exec.out_value      = d_ov ? opnd : '0;
      rr_exec.screen_valid   = d_sv;
      rr_exec.screen_setting = d_sv ? ra : '0;
      rr_exec.screen_value   = d_sv ? opnd : '0;
      rr_exec.input_taken    = d_it;
      rr_exec.key_taken      = d_kt;
    end
  end

  // Item capture and the result being built.
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      item <= in_data;
      rr   <= '0;
    end else if (cmd.set_halt) begin
      rr.stopped <= 1'b1;
    end else if (cmd.set_err3) begin
      rr.error_code <= bccs_pkg::ERR_NO_PERS;
    end else if (cmd.exec) begin
      rr <= rr_exec;
    end
  end

  // Finished word with the committed pc and register 1.
  always_comb begin
    res_next         = rr;
    res_next.pc_now  = pc;
    res_next.reg_one = reg1;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.res_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
    if (cmd.res_load) begin
      res_data <= res_next;
    end
  end

  // Status to the controller.
  always_comb begin
    sts             = '0;
    sts.red_done    = red_done;
    sts.halt_hit    = halt_en && (pc == halt_addr);
    sts.persist_en  = persist_en;
    sts.cmd         = item.cmd;
    sts.err_any     = (d_err != bccs_pkg::ERR_NONE);
    sts.mkind       = d_mk;
    sts.mem_persist = d_mp;
    sts.mlen_m1     = d_mlen;
    sts.out_free    = !res_valid || res_ready;
  end

endmodule

`default_nettype wire

[verif/testbench.sv]
// Self-checking testbench for the byte-coded processor step unit.
`timescale 1ns / 1ps

module testbench;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  bccs_pkg::in_t in_data = '0;
  logic res_valid;
  logic res_ready = 1'b0;
  bccs_pkg::out_t res_data;
  logic cfg_we = 1'b0;
  logic [bccs_pkg::CFG_IW-1:0] cfg_index = '0;
  logic [bccs_pkg::CFG_DW-1:0] cfg_data = '0;

  byte_coded_cpu_step_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .res_valid(res_valid), .res_ready(res_ready), .res_data(res_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow state of the processor, advanced as each word is queued.
  logic [7:0] main_mem [0:65535];
  logic [7:0] pers_mem [0:4095];
  bit main_known [0:65535];
  bit pers_known [0:4095];
  logic [31:0] regs [0:15];
  logic [31:0] pc;
  logic cmp_ok;
  logic [31:0] cmp_a, cmp_b;
  logic pers_on, halt_on;
  logic [31:0] halt_pc;

  bccs_pkg::in_t pending_words [$];
  bccs_pkg::out_t expected_results [$];
  int send_idle_pct = 0, recv_idle_pct = 0;
  int words_sent = 0, execs_sent = 0, results_seen = 0, errors = 0;
  logic in_fire = 1'b0;

  function automatic logic [31:0] fetch(logic [31:0] addr, int n);
    logic [31:0] v;
    v = '0;
    for (int i = 0; i < n; i++) v = (v << 8) | main_mem[16'(addr + i)];
    return v;
  endfunction

  // Execute one instruction on the shadow state; returns the error code.
  function automatic logic [2:0] run_instr(bccs_pkg::in_t x, inout bccs_pkg::out_t o);
    logic [7:0] op, b1, b2, base;
    logic [31:0] imm, opnd, nxt, a, r, v;
    logic [3:0] dst, fn;
    logic [2:0] mc;
    logic im, take;
    int n;
    op = main_mem[16'(pc)];
    b1 = main_mem[16'(pc + 1)];
    b2 = main_mem[16'(pc + 2)];
    imm = fetch(pc + 2, 2);
    im = op[4];
    opnd = im ? imm : regs[b2[3:0]];
    dst = b1[7:4];
    nxt = pc + 1;
    take = 1'b0;
    if (op == bccs_pkg::OP_NOP) begin
    end else if (op == bccs_pkg::OP_IN) begin
      regs[dst] = x.input_available ? x.input_word : '0;
      o.input_taken = x.input_available;
      nxt = pc + 2;
    end else if (op == bccs_pkg::OP_OUT || op == bccs_pkg::OP_OUTI) begin
      o.out_valid = 1'b1;
      o.out_value = (op == bccs_pkg::OP_OUT) ? regs[b2[3:0]] : imm;
      nxt = pc + ((op == bccs_pkg::OP_OUT) ? 3 : 4);
    end else if (op == bccs_pkg::OP_KEY) begin
      regs[dst] = x.key_available ? x.key_word : '0;
      o.key_taken = x.key_available;
      nxt = pc + 2;
    end else if (op == bccs_pkg::OP_SCR || op == bccs_pkg::OP_SCRI) begin
      o.screen_valid = 1'b1;
      o.screen_setting = regs[b1[3:0]];
      o.screen_value = opnd;
      nxt = pc + (im ? 4 : 3);
    end else if (op == bccs_pkg::OP_TLO || op == bccs_pkg::OP_THI) begin
      regs[dst] = (op == bccs_pkg::OP_TLO) ? x.time_now[31:0] : x.time_now[63:32];
      nxt = pc + 2;
    end else if (op == bccs_pkg::OP_PC) begin
      regs[dst] = pc;
      if (dst == 4'd15) cmp_ok = 1'b0;
      nxt = pc + 2;
    end else if (op >= bccs_pkg::OP_ALU_LO && op <= bccs_pkg::OP_ALU_HI
                 && op[3:0] <= bccs_pkg::ALU_CMP) begin
      a = regs[b1[3:0]];
      r = opnd;
      fn = op[3:0];
      nxt = pc + (im ? 4 : 3);
      if (fn == bccs_pkg::ALU_CMP) begin
        cmp_ok = 1'b1;
        cmp_a = a;
        cmp_b = r;
        regs[dst] = '0;
      end else begin
        case (fn)
          bccs_pkg::ALU_NAND: v = ~(a & r);
          bccs_pkg::ALU_OR:   v = a | r;
          bccs_pkg::ALU_AND:  v = a & r;
          bccs_pkg::ALU_NOR:  v = ~(a | r);
          bccs_pkg::ALU_ADD:  v = a + r;
          bccs_pkg::ALU_SUB:  v = a - r;
          bccs_pkg::ALU_XOR:  v = a ^ r;
          bccs_pkg::ALU_SHL:  v = (r < 32) ? a << r[4:0] : '0;
          bccs_pkg::ALU_SHR:  v = (r < 32) ? a >> r[4:0] : '0;
          default: v = (r < 32) ? 32'($signed(a) >>> r[4:0]) : {32{a[31]}};
        endcase
        regs[dst] = v;
        if (dst == 4'd15) cmp_ok = 1'b0;
      end
    end else if (op >= bccs_pkg::OP_BR_LO && op <= bccs_pkg::OP_BR_HI) begin
      base = op & bccs_pkg::BR_MASK;
      nxt = pc + (im ? 4 : 3);
      if (base == bccs_pkg::BR_ALWAYS) begin
        take = 1'b1;
      end else begin
        if (!cmp_ok) return bccs_pkg::ERR_NO_CMP;
        case (base)
          bccs_pkg::BR_EQ:  take = cmp_a == cmp_b;
          bccs_pkg::BR_NE:  take = cmp_a != cmp_b;
          bccs_pkg::BR_LTU: take = cmp_a < cmp_b;
          bccs_pkg::BR_GEU: take = cmp_a >= cmp_b;
          bccs_pkg::BR_LEU: take = cmp_a <= cmp_b;
          bccs_pkg::BR_GTU: take = cmp_a > cmp_b;
          bccs_pkg::BR_LT:  take = $signed(cmp_a) < $signed(cmp_b);
          bccs_pkg::BR_GE:  take = $signed(cmp_a) >= $signed(cmp_b);
          bccs_pkg::BR_LE:  take = $signed(cmp_a) <= $signed(cmp_b);
          bccs_pkg::BR_GT:  take = $signed(cmp_a) > $signed(cmp_b);
          default: return bccs_pkg::ERR_BAD_BR;
        endcase
      end
      if (take) nxt = opnd;
    end else if (op >= bccs_pkg::OP_MEM_LO && op <= bccs_pkg::OP_MEM_HI) begin
      mc = op[2:0];
      nxt = pc + (im ? 4 : 3);
      if (mc == bccs_pkg::MC_PLOAD || mc == bccs_pkg::MC_PSTORE) begin
        if (!pers_on) return bccs_pkg::ERR_NO_PERS;
        if (mc == bccs_pkg::MC_PLOAD) begin
          v = '0;
          for (int i = 0; i < 4; i++) v = (v << 8) | pers_mem[12'(opnd + i)];
          regs[dst] = v;
        end else begin
          for (int i = 0; i < 4; i++) begin
            pers_mem[12'(opnd + i)] = regs[b1[3:0]][8*(3-i) +: 8];
            pers_known[12'(opnd + i)] = 1'b1;
          end
        end
      end else begin
        n = (mc[1:0] == 2'd0) ? 1 : ((mc[1:0] == 2'd1) ? 2 : 4);
        if (!mc[2]) begin
          regs[dst] = fetch(opnd, n);
          if (dst == 4'd15) cmp_ok = 1'b0;
        end else begin
          v = regs[b1[3:0]];
          for (int i = 0; i < n; i++) begin
            main_mem[16'(opnd + i)] = v[8*(n-1-i) +: 8];
            main_known[16'(opnd + i)] = 1'b1;
          end
        end
      end
    end else begin
      return bccs_pkg::ERR_BAD_OP;
    end
    regs[0] = '0;
    if (nxt == pc) o.stopped = 1'b1;
    pc = nxt;
    return bccs_pkg::ERR_NONE;
  endfunction

  // Predict the result of one word and queue both.
  task automatic send(bccs_pkg::in_t x);
    bccs_pkg::out_t o;
    logic [2:0] err;
    o = '0;
    case (x.cmd)
      bccs_pkg::CMD_WMAIN: begin
        main_mem[x.load_address] = x.load_byte;
        main_known[x.load_address] = 1'b1;
      end
      bccs_pkg::CMD_WPERS: begin
        if (pers_on) begin
          pers_mem[x.load_address[11:0]] = x.load_byte;
          pers_known[x.load_address[11:0]] = 1'b1;
        end else begin
          o.error_code = bccs_pkg::ERR_NO_PERS;
        end
      end
      bccs_pkg::CMD_EXEC: begin
        if (halt_on && pc == halt_pc) begin
          o.stopped = 1'b1;
        end else begin
          err = run_instr(x, o);
          if (err != bccs_pkg::ERR_NONE) begin
            o = '0;
            o.error_code = err;
          end
        end
      end
      default: ;
    endcase
    o.pc_now = pc;
    o.reg_one = regs[1];
    expected_results.push_back(o);
    pending_words.push_back(x);
    words_sent++;
    if (x.cmd == bccs_pkg::CMD_EXEC) execs_sent++;
  endtask

  function automatic bccs_pkg::in_t rand_word(logic [1:0] c);
    bccs_pkg::in_t x;
    x.cmd = c;
    x.load_address = 16'($urandom);
    x.load_byte = 8'($urandom);
    x.input_available = 1'($urandom);
    x.input_word = $urandom;
    x.key_available = 1'($urandom);
    x.key_word = $urandom;
    x.time_now = {$urandom, $urandom};
    return x;
  endfunction

  task automatic write_byte(logic [1:0] c, logic [15:0] addr, logic [7:0] val);
    bccs_pkg::in_t x;
    x = rand_word(c);
    x.load_address = addr;
    x.load_byte = val;
    send(x);
  endtask

  // Place an instruction at pc, keeping known bytes when fresh is clear, fill any bytes it reads, then execute it.
  task automatic exec_op(logic [7:0] op, logic [7:0] b1, logic [15:0] imm, bit fresh);
    logic [7:0] bytes [4];
    logic [31:0] opnd;
    logic [7:0] cur;
    int n;
    bytes = '{op, b1, imm[15:8], imm[7:0]};
    for (int i = 0; i < 4; i++)
      if (fresh) write_byte(bccs_pkg::CMD_WMAIN, 16'(pc + i), bytes[i]);
      else if (!main_known[16'(pc + i)])
        write_byte(bccs_pkg::CMD_WMAIN, 16'(pc + i), bytes[i]);
    cur = main_mem[16'(pc)];
    opnd = cur[4] ? fetch(pc + 2, 2) : regs[main_mem[16'(pc + 2)][3:0]];
    if (cur >= bccs_pkg::OP_MEM_LO && cur <= bccs_pkg::OP_MEM_HI) begin
      if (cur[2:0] == bccs_pkg::MC_PLOAD) begin
        if (pers_on)
          for (int i = 0; i < 4; i++)
            if (!pers_known[12'(opnd + i)])
              write_byte(bccs_pkg::CMD_WPERS, 16'(12'(opnd + i)), 8'($urandom));
      end else if (!cur[2]) begin
        n = (cur[1:0] == 2'd0) ? 1 : ((cur[1:0] == 2'd1) ? 2 : 4);
        for (int i = 0; i < n; i++)
          if (!main_known[16'(opnd + i)])
            write_byte(bccs_pkg::CMD_WMAIN, 16'(opnd + i), 8'($urandom));
      end
    end
    send(rand_word(bccs_pkg::CMD_EXEC));
  endtask

  // Pick a random instruction, weighted toward the legal ones.
  task automatic random_instr();
    logic [7:0] op;
    logic [15:0] imm;
    imm = 16'($urandom);
    case ($urandom_range(0, 11))
      0: op = 8'($urandom_range(0, 7));
      1: op = $urandom_range(0, 1) ? bccs_pkg::OP_OUTI : bccs_pkg::OP_SCRI;
      2, 3, 4: begin
        op = {3'b001, 1'($urandom), 4'($urandom_range(0, 10))};
        if ($urandom_range(0, 3) == 0) imm = 16'($urandom_range(0, 40));
      end
      5, 6: begin
        op = 8'($urandom_range(bccs_pkg::OP_BR_LO, bccs_pkg::OP_BR_HI));
        if ($urandom_range(0, 3) == 0) imm = pc[15:0];
      end
      7, 8: op = 8'($urandom_range(bccs_pkg::OP_MEM_LO, bccs_pkg::OP_MEM_HI));
      9: op = $urandom_range(0, 1) ? 8'($urandom_range(8'h78, 8'hff))
                                   : 8'($urandom_range(8'h08, 8'h1f));
      10: op = 8'($urandom_range(8'h2b, 8'h2f));
      default: op = {3'b001, 1'($urandom), 4'($urandom_range(0, 10))};
    endcase
    exec_op(op, 8'($urandom), imm, $urandom_range(0, 9) != 0);
  endtask

  task automatic settle();
    wait (pending_words.size() == 0 && expected_results.size() == 0);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_cfg(logic [bccs_pkg::CFG_IW-1:0] idx, logic [31:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      bccs_pkg::CFG_PERSIST_EN: pers_on = val[0];
      bccs_pkg::CFG_HALT_EN: halt_on = val[0];
      default: halt_pc = val;
    endcase
  endtask

  // Stimulus: directed cases, then random phases with changing settings.
  initial begin
    logic [31:0] hp;
    for (int i = 0; i < 16; i++) regs[i] = '0;
    pc = '0;
    cmp_ok = 1'b0;
    cmp_a = '0;
    cmp_b = '0;
    pers_on = 1'b0;
    halt_on = 1'b0;
    halt_pc = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    send_idle_pct = 10;
    recv_idle_pct = 48;

    // Persistent write while disabled, then the unused command.
    write_byte(bccs_pkg::CMD_WPERS, 16'hffff, 8'hff);
    send(rand_word(2'd3));
    exec_op(bccs_pkg::BR_EQ, 8'h00, 16'h0000, 1);    // branch before any compare
    exec_op(bccs_pkg::OP_IN, 8'h10, 16'h0000, 1);
    exec_op(8'h3a, 8'h01, 16'hffff, 1);              // compare with immediate
    exec_op(8'h4e, 8'h00, 16'h0000, 1);              // unknown branch condition
    exec_op(8'h37, 8'h11, 16'd40, 1);                // shift left by 40
    exec_op(8'h39, 8'h21, 16'd33, 1);                // arithmetic shift by 33
    exec_op(8'h34, 8'h01, 16'hffff, 1);              // write to register 0
    exec_op(8'hff, 8'h00, 16'h0000, 1);              // bad opcode
    exec_op(8'h58, 8'h00, pc[15:0], 1);              // jump to self
    settle();
    write_cfg(bccs_pkg::CFG_PERSIST_EN, 32'd1);
    exec_op(8'h77, 8'h10, 16'hfffe, 1);              // persistent store at the wrap
    exec_op(8'h73, 8'h20, 16'hfffe, 1);

    for (int ph = 0; words_sent < 1000; ph++) begin
      if (words_sent > 330) begin
        send_idle_pct = 48;
        recv_idle_pct = 10;
      end
      if (words_sent > 660) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      settle();
      case (ph % 4)
        0: hp = pc;
        1: hp = 32'hffff_ffff;
        2: hp = '0;
        default: hp = $urandom;
      endcase
      write_cfg(bccs_pkg::CFG_PERSIST_EN, 32'($urandom_range(0, 1)));
      write_cfg(bccs_pkg::CFG_HALT_EN, 32'(ph % 3 != 2));
      write_cfg(bccs_pkg::CFG_HALT_ADDR, hp);
      for (int k = 0; k < ((ph % 4 == 0) ? 3 : 20); k++) begin
        if ($urandom_range(0, 7) == 0)
          send(rand_word(2'($urandom_range(0, 3))));
        else
          random_instr();
      end
    end

    settle();
    $display("Ran %0d words, %0d of them executed instructions, over several settings.",
             words_sent, execs_sent);
    $display("Checked %0d results with %0d mismatches.", results_seen, errors);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Driver: present the next word at the falling edge.
  always @(posedge clk) in_fire <= in_valid && in_ready;

  always @(negedge clk) begin
    if (!rst && (!in_valid || in_fire)) begin
      if (pending_words.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        in_valid <= 1'b1;
        in_data <= pending_words.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    res_ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: mismatch in %s: expected %h, actual %h", $time, name, want, got);
      errors++;
    end
  endtask

  // Monitor: compare each accepted result word with the oldest prediction.
  always @(posedge clk) begin
    bccs_pkg::out_t want;
    if (!rst && res_valid && res_ready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result word, expected none, actual %h", $time, res_data);
        errors++;
      end else begin
        want = expected_results.pop_front();
        check_field("stopped", 32'(want.stopped), 32'(res_data.stopped));
        check_field("error_code", 32'(want.error_code), 32'(res_data.error_code));
        check_field("out_valid", 32'(want.out_valid), 32'(res_data.out_valid));
        check_field("out_value", want.out_value, res_data.out_value);
        check_field("screen_valid", 32'(want.screen_valid), 32'(res_data.screen_valid));
        check_field("screen_setting", want.screen_setting, res_data.screen_setting);
        check_field("screen_value", want.screen_value, res_data.screen_value);
        check_field("input_taken", 32'(want.input_taken), 32'(res_data.input_taken));
        check_field("key_taken", 32'(want.key_taken), 32'(res_data.key_taken));
        check_field("pc_now", want.pc_now, res_data.pc_now);
        check_field("reg_one", want.reg_one, res_data.reg_one);
      end
    end
  end

  // Watchdog for a hung run.
  initial begin
    #40ms;
    $display("Timed out with %0d words pending and %0d results outstanding.",
             pending_words.size(), expected_results.size());
    $display("status: fail");
    $finish;
  end

endmodule

[files.f]
rtl/bccs_pkg.sv
rtl/bccs_mod.sv
rtl/bccs_ctrl.sv
rtl/bccs_dp.sv
rtl/byte_coded_cpu_step_unit.sv
verif/testbench.sv
